/* rtl/slr_pkg.sv */
// ============================================================================
// slr_pkg - scope reference ledger shared types
// Operation and status codes, payload structs and the front-to-back command.
// ============================================================================
`default_nettype none

package slr_pkg;

    // Command count fields are sized for the largest ledger (64 entries plus one).
    localparam int CMD_CNT_W = 7;
    localparam int HANDLE_W  = 32;
    localparam int OVF_W     = 16;
    localparam logic [OVF_W-1:0] OVF_MAX = '1;

    typedef enum logic [1:0] {
        OP_ENTER    = 2'd0,
        OP_TRACK    = 2'd1,
        OP_EXIT     = 2'd2,
        OP_SHUTDOWN = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_NO_SCOPE = 3'd4
    } status_t;

    typedef struct packed {
        op_t                 operation;
        logic [HANDLE_W-1:0] handle;
        logic                immortal;
    } in_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] released_handle;
        logic                release_valid;
        logic                last;
        status_t             status;
    } out_item_t;

    typedef enum logic [1:0] {
        CK_REPORT  = 2'd0,
        CK_WRITE   = 2'd1,
        CK_RELEASE = 2'd2
    } cmd_kind_t;

    // hi is the write address for CK_WRITE, the ledger count for CK_RELEASE
    typedef struct packed {
        cmd_kind_t            kind;
        status_t              status;
        logic [HANDLE_W-1:0]  handle;
        logic [CMD_CNT_W-1:0] lo;
        logic [CMD_CNT_W-1:0] hi;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/scope_reference_ledger.sv */
// ============================================================================
// scope_reference_ledger - nested-scope handle ledger
// Tracks object handles in nested scopes and releases them on scope exit.
// ============================================================================
// Enter and track items are taken one per cycle while the command queue has
// room; each gives one result. Exit and shutdown items that close a real scope
// hold the input while the scope mark is fetched from the mark memory; the
// others do not. The back end then reads the ledger memory one entry per cycle
// while pop keeps up, so an exit that releases n handles delivers them newest
// first, each read through a registered memory output. The result queue (four
// deep) lets results wait for pop while new items are still taken. After reset
// the block is ready at once; no clearing pass is needed.
`default_nettype none

module scope_reference_ledger #(
    parameter int MAX_SCOPES  = 16,
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire slr_pkg::in_item_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output slr_pkg::out_item_t      result
);

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    logic                               cmd_push;
    logic                               cmd_pop;
    logic                               cmd_full;
    logic                               cmd_empty;
    slr_pkg::cmd_t                      cmd_in;
    slr_pkg::cmd_t                      cmd_out;
    logic                               out_push;
    slr_pkg::out_item_t                 out_item;
    logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

    slr_front #(
        .MAX_SCOPES  (MAX_SCOPES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    slr_fifo #(
        .DEPTH (CMD_DEPTH),
        .T     (slr_pkg::cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .full  (cmd_full),
        .empty (cmd_empty),
        .count ()
    );

    slr_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    slr_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (slr_pkg::out_item_t)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .pop   (pop),
        .rdata (result),
        .full  (),
        .empty (empty),
        .count (out_count)
    );

    // front end never pushes a command into a full queue
    a_cmd_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

    // back end never stages a result without a free slot
    a_out_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count != OUT_DEPTH[$clog2(OUT_DEPTH+1)-1:0]) || pop)
        else $error("result pushed into full queue");

    // a result without a release always closes its item
    a_report_last : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.release_valid) |-> result.last)
        else $error("non-release result without last");

    // release transfers always report done
    a_release_status : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.release_valid) |-> (result.status == slr_pkg::ST_DONE))
        else $error("release result with non-done status");

endmodule

`default_nettype wire

/* rtl/slr_fifo.sv */
// ============================================================================
// slr_fifo - small synchronous queue
// Register-based queue; DEPTH must be a power of two of at least two.
// ============================================================================
`default_nettype none

module slr_fifo #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire T                           wdata,
    input  wire logic                       pop,
    output T                                rdata,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    T                store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* rtl/slr_front.sv */
// ============================================================================
// slr_front - scope bookkeeping and item classification
// Owns the mark stack, open/overflow scope counts and the ledger count, and
// turns each item into one command for the back end.
// ============================================================================
`default_nettype none

module slr_front #(
    parameter int MAX_SCOPES  = 16,
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire slr_pkg::in_item_t item,
    output logic                  full,
    output logic                  cmd_push,
    output slr_pkg::cmd_t         cmd,
    input  wire logic             cmd_full
);

    localparam int SCP_W  = $clog2(MAX_SCOPES+1);
    localparam int SADR_W = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES+1);
    localparam int OVF_W  = slr_pkg::OVF_W;
    localparam int CCW    = slr_pkg::CMD_CNT_W;

    typedef enum logic {
        F_IDLE,
        F_MARK
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [SCP_W-1:0]     open_reg, open_next;
    logic [OVF_W-1:0]     ovf_reg, ovf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [CNT_W-1:0]     mark_mem [MAX_SCOPES];
    logic [CNT_W-1:0]     mark_q;
    logic                 mark_we;
    logic                 mark_re;
    logic [SADR_W-1:0]    mark_wa;
    logic [SADR_W-1:0]    mark_ra;
    logic                 accept;

    assign full   = (state_reg != F_IDLE) || cmd_full;
    assign accept = push && !full;

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        mark_we    = 1'b0;
        mark_re    = 1'b0;
        mark_wa    = SADR_W'(open_reg);
        mark_ra    = '0;
        cmd_push   = 1'b0;
        cmd.kind   = slr_pkg::CK_REPORT;
        cmd.status = slr_pkg::ST_DONE;
        cmd.handle = item.handle;
        cmd.lo     = '0;
        cmd.hi     = CCW'(cnt_reg);

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.operation)
                        slr_pkg::OP_ENTER:
                        begin
                            cmd_push = 1'b1;
                            if (open_reg == SCP_W'(MAX_SCOPES))
                            begin
                                cmd.status = slr_pkg::ST_OVERFLOW;
                                if (ovf_reg != slr_pkg::OVF_MAX)
                                    ovf_next = ovf_reg + 1'b1;
                            end
                            else
                            begin
                                mark_we   = 1'b1;
                                open_next = open_reg + 1'b1;
                            end
                        end
                        slr_pkg::OP_TRACK:
                        begin
                            cmd_push = 1'b1;
                            if (item.handle == '0 || item.immortal)
                                cmd.status = slr_pkg::ST_IGNORED;
                            else if (cnt_reg == CNT_W'(MAX_ENTRIES))
                                cmd.status = slr_pkg::ST_FULL;
                            else
                            begin
                                cmd.kind = slr_pkg::CK_WRITE;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        slr_pkg::OP_EXIT:
                        begin
                            if (ovf_reg != '0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = slr_pkg::ST_OVERFLOW;
                                ovf_next   = ovf_reg - 1'b1;
                            end
                            else if (open_reg == '0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = slr_pkg::ST_NO_SCOPE;
                            end
                            else
                            begin
                                // innermost mark comes out of the mark memory next cycle
                                mark_re    = 1'b1;
                                mark_ra    = SADR_W'(open_reg - 1'b1);
                                open_next  = open_reg - 1'b1;
                                state_next = F_MARK;
                            end
                        end
                        slr_pkg::OP_SHUTDOWN:
                        begin
                            ovf_next = '0;
                            if (open_reg == '0)
                                cmd_push = 1'b1;
                            else
                            begin
                                mark_re    = 1'b1;
                                open_next  = '0;
                                state_next = F_MARK;
                            end
                        end
                    endcase
                end
            end
            F_MARK:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    cmd.kind   = slr_pkg::CK_RELEASE;
                    cmd.lo     = CCW'(mark_q);
                    if (cnt_reg > mark_q)
                        cnt_next = mark_q;
                    state_next = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            open_reg  <= '0;
            ovf_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= cnt_reg;
        if (mark_re)
            mark_q <= mark_mem[mark_ra];
    end

endmodule

`default_nettype wire

/* rtl/slr_back.sv */
// ============================================================================
// slr_back - ledger memory and release sequencer
// Executes commands: writes tracked handles, reports status, and walks the
// ledger from the top down to a mark, one release per cycle while the result queue has room.
// ============================================================================
`default_nettype none

module slr_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int OUT_DEPTH   = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_empty,
    input  wire slr_pkg::cmd_t                cmd,
    output logic                              cmd_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                              out_push,
    output slr_pkg::out_item_t                out_item
);

    localparam int EADR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCW    = $clog2(OUT_DEPTH+1);
    localparam int CCW    = slr_pkg::CMD_CNT_W;
    localparam int HW     = slr_pkg::HANDLE_W;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [CCW-1:0]       cur_reg, cur_next;
    logic [CCW-1:0]       lo_reg, lo_next;
    logic                 s_vld_reg, s_vld_next;
    logic                 s_mem_reg, s_mem_next;
    logic                 s_last_reg, s_last_next;
    slr_pkg::status_t     s_status_reg, s_status_next;

    logic [HW-1:0]        ledger_mem [MAX_ENTRIES];
    logic [HW-1:0]        rd_q;
    logic                 led_we;
    logic                 led_re;
    logic [EADR_W-1:0]    led_wa;
    logic [EADR_W-1:0]    led_ra;
    logic [CCW-1:0]       top_idx;
    logic [CCW-1:0]       run_idx;
    logic                 room;

    // the staged result already holds a slot of the result queue
    assign room    = ({1'b0, out_count} + {{OCW{1'b0}}, s_vld_reg}) < (OCW+1)'(OUT_DEPTH);
    assign top_idx = cmd.hi - 1'b1;
    assign run_idx = cur_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        lo_next       = lo_reg;
        s_vld_next    = 1'b0;
        s_mem_next    = 1'b0;
        s_last_next   = 1'b1;
        s_status_next = slr_pkg::ST_DONE;
        cmd_pop       = 1'b0;
        led_we        = 1'b0;
        led_re        = 1'b0;
        led_wa        = EADR_W'(cmd.hi);
        led_ra        = EADR_W'(top_idx);

        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty && room)
                begin
                    cmd_pop    = 1'b1;
                    s_vld_next = 1'b1;
                    unique case (cmd.kind)
                        slr_pkg::CK_WRITE:
                            led_we = 1'b1;
                        slr_pkg::CK_REPORT:
                            s_status_next = cmd.status;
                        slr_pkg::CK_RELEASE:
                        begin
                            if (cmd.hi > cmd.lo)
                            begin
                                led_re      = 1'b1;
                                s_mem_next  = 1'b1;
                                s_last_next = (top_idx == cmd.lo);
                                cur_next    = top_idx;
                                lo_next     = cmd.lo;
                                if (top_idx != cmd.lo)
                                    state_next = B_RUN;
                            end
                        end
                        default:
                            s_status_next = cmd.status;
                    endcase
                end
            end
            B_RUN:
            begin
                if (room)
                begin
                    led_re      = 1'b1;
                    led_ra      = EADR_W'(run_idx);
                    s_vld_next  = 1'b1;
                    s_mem_next  = 1'b1;
                    s_last_next = (run_idx == lo_reg);
                    cur_next    = run_idx;
                    if (run_idx == lo_reg)
                        state_next = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            s_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s_vld_reg <= s_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        lo_reg       <= lo_next;
        s_mem_reg    <= s_mem_next;
        s_last_reg   <= s_last_next;
        s_status_reg <= s_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (led_we)
            ledger_mem[led_wa] <= cmd.handle;
        if (led_re)
            rd_q <= ledger_mem[led_ra];
    end

    assign out_push = s_vld_reg;

    always_comb
    begin
        if (s_mem_reg)
        begin
            out_item.released_handle = rd_q;
            out_item.release_valid   = 1'b1;
            out_item.last            = s_last_reg;
            out_item.status          = slr_pkg::ST_DONE;
        end
        else
        begin
            out_item.released_handle = '0;
            out_item.release_valid   = 1'b0;
            out_item.last            = 1'b1;
            out_item.status          = s_status_reg;
        end
    end

endmodule

`default_nettype wire
